>>> hw/rtl/clsr_pkg.sv
// Package for the combined LCG shuffle generator: widths, generator constants,
// sequencer state type and the request/result structs of the shared mulmod unit.
// No dependencies.
`timescale 1ns / 1ps

package clsr_pkg;

    // Payload widths
    localparam int VALUE_W = 31;
    localparam int MUL_W   = 16;
    localparam int FOLD_W  = 8;
    localparam int PROD_W  = VALUE_W + MUL_W;

    // Shuffle table geometry
    localparam int TABLE_SIZE  = 64;
    localparam int TBL_IDX_W   = $clog2(TABLE_SIZE);
    localparam int SLOT_PROD_W = VALUE_W + TBL_IDX_W + 1;
    localparam int SLOT_Q_W    = TBL_IDX_W + 2;

    // Generator constants; each modulus is 2^31 minus the fold constant
    localparam logic [MUL_W-1:0]   MUL_ONE  = 16'd40014;
    localparam logic [MUL_W-1:0]   MUL_TWO  = 16'd40692;
    localparam logic [VALUE_W-1:0] MOD_ONE  = 31'd2147483563;
    localparam logic [VALUE_W-1:0] MOD_TWO  = 31'd2147483399;
    localparam logic [FOLD_W-1:0]  FOLD_ONE = 8'd85;
    localparam logic [FOLD_W-1:0]  FOLD_TWO = 8'd249;

    localparam logic [VALUE_W-1:0] SEED_RESET = 31'd42;

    // Which generator an operation belongs to
    typedef enum logic {
        GEN_ONE,
        GEN_TWO
    } gen_sel_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE_ONE,
        ST_ISSUE_TWO,
        ST_WAIT,
        ST_DIFF,
        ST_FILL_WR,
        ST_SLOT,
        ST_READ,
        ST_TAKE,
        ST_DONE
    } state_t;

    // Operation issued to the mulmod unit
    typedef struct packed {
        logic                valid;
        gen_sel_t            sel;
        logic [VALUE_W-1:0]  x;
    } mm_req_t;

    // Result returned by the mulmod unit
    typedef struct packed {
        logic                valid;
        gen_sel_t            sel;
        logic [VALUE_W-1:0]  value;
    } mm_rsp_t;

endpackage

>>> hw/rtl/clsr_if.sv
// Handshake channels of the generator: request channel in, value channel out.
// Depends on clsr_pkg for the value width.
`timescale 1ns / 1ps

interface rng_req_if;
    logic valid;
    logic ready;
    logic request;

    modport source (output valid, output request, input ready);
    modport sink   (input valid, input request, output ready);
endinterface

interface rng_val_if;
    logic                         valid;
    logic                         ready;
    logic [clsr_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hw/rtl/clsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/clsr_mulmod.sv
// Shared modular multiply unit: x * a mod (2^31 - c) for either generator,
// three stages (multiply, first fold, second fold with final subtract). Uses clsr_pkg.
`timescale 1ns / 1ps

module clsr_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  clsr_pkg::mm_req_t req,
    output clsr_pkg::mm_rsp_t rsp
);
    import clsr_pkg::*;

    logic              s1_valid_reg;
    gen_sel_t          s1_sel_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s2_valid_reg;
    gen_sel_t          s2_sel_reg;
    logic [31:0]       s2_fold_reg;

    logic [MUL_W-1:0]   mul;
    logic [FOLD_W-1:0]  c1;
    logic [FOLD_W-1:0]  c2;
    logic [VALUE_W-1:0] m2;
    logic [31:0]        fold1;
    logic [31:0]        fold2;
    logic [31:0]        reduced;

    // Multiplier constant for the issued generator
    assign mul = (req.sel == GEN_ONE) ? MUL_ONE : MUL_TWO;

    // First fold: hi * 2^31 is congruent to hi * c
    assign c1    = (s1_sel_reg == GEN_ONE) ? FOLD_ONE : FOLD_TWO;
    assign fold1 = 32'(s1_prod_reg[VALUE_W-1:0])
                 + 32'(s1_prod_reg[PROD_W-1:VALUE_W]) * 32'(c1);

    // Second fold leaves a value below 2m; one conditional subtract finishes
    assign c2      = (s2_sel_reg == GEN_ONE) ? FOLD_ONE : FOLD_TWO;
    assign m2      = (s2_sel_reg == GEN_ONE) ? MOD_ONE : MOD_TWO;
    assign fold2   = 32'(s2_fold_reg[VALUE_W-1:0])
                   + (s2_fold_reg[31] ? 32'(c2) : 32'd0);
    assign reduced = (fold2 >= 32'(m2)) ? (fold2 - 32'(m2)) : fold2;

    assign rsp.valid = s2_valid_reg;
    assign rsp.sel   = s2_sel_reg;
    assign rsp.value = reduced[VALUE_W-1:0];

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        s1_sel_reg  <= req.sel;
        s1_prod_reg <= PROD_W'(req.x) * PROD_W'(mul);
        s2_sel_reg  <= s1_sel_reg;
        s2_fold_reg <= fold1;
    end

endmodule

>>> hw/rtl/combined_lcg_shuffle_rng_core.sv
// Top level of the combined LCG shuffle generator: sequencer, generator state,
// slot computation and output register. Uses clsr_pkg, the channel interfaces,
// clsr_mulmod and clsr_ram.
`timescale 1ns / 1ps

// Each accepted request with request=1 returns one value, the numerator of a
// uniform fraction over 2147483563. A normal request runs through the states
// ISSUE_ONE, ISSUE_TWO, WAIT, DIFF, SLOT, READ, TAKE and DONE, which loads the
// value once the output register is free and only then takes the next request:
// both generators go one after the other through a single three-stage modular
// multiplier, then the difference, the table slot and one read-modify-write of
// the 64-entry shuffle RAM follow. The first request after reset or after a
// seed write also fills the table: 64 rounds of two multiplier passes plus the
// difference and the RAM write. A request with request=0 is taken in IDLE and
// gives no value. The next request is taken while a value still waits at the
// output. Write the seed only while the block is idle.
module combined_lcg_shuffle_rng_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [clsr_pkg::VALUE_W-1:0] cfg_wdata,
    rng_req_if.sink                      req,
    rng_val_if.source                    rsp
);
    import clsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [VALUE_W-1:0]     seed_reg;
    logic                   need_fill_reg;
    logic                   fill_reg;
    logic [TBL_IDX_W-1:0]   fill_idx_reg;
    logic [VALUE_W-1:0]     gen_one_reg;
    logic [VALUE_W-1:0]     gen_two_reg;
    logic [VALUE_W-1:0]     prev_reg;
    logic [VALUE_W-1:0]     diff_reg;
    logic [SLOT_PROD_W-1:0] slot_prod_reg;
    logic [TBL_IDX_W-1:0]   slot_reg;
    logic [VALUE_W-1:0]     result_reg;
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     out_value_reg;

    mm_req_t                mm_req;
    mm_rsp_t                mm_rsp;

    logic                   accept;
    logic                   out_load;
    logic                   fill_last;
    logic                   ram_we;
    logic [TBL_IDX_W-1:0]   ram_waddr;
    logic                   ram_re;
    logic [VALUE_W-1:0]     ram_rdata;

    logic [31:0]            diff_raw;
    logic [31:0]            diff_wrap;
    logic [TBL_IDX_W:0]     slot_q0;
    logic [31:0]            slot_sum;
    logic [SLOT_Q_W-1:0]    slot_q;
    logic [TBL_IDX_W-1:0]   slot_val;

    // Shared modular multiplier
    clsr_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // Shuffle table
    clsr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (diff_reg),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Combined difference, wrapped into [0, MOD_ONE)
    assign diff_raw  = 32'(gen_one_reg) - 32'(gen_two_reg);
    assign diff_wrap = (gen_one_reg >= gen_two_reg) ? diff_raw
                                                    : diff_raw + 32'(MOD_ONE);

    // Slot = floor(TABLE_SIZE * prev / MOD_ONE) with one correction step
    assign slot_q0  = slot_prod_reg[SLOT_PROD_W-1:VALUE_W];
    assign slot_sum = 32'(slot_prod_reg[VALUE_W-1:0]) + 32'(slot_q0) * 32'(FOLD_ONE);
    assign slot_q   = SLOT_Q_W'(slot_q0)
                    + SLOT_Q_W'(slot_sum >= 32'(MOD_ONE));
    assign slot_val = (slot_q > SLOT_Q_W'(TABLE_SIZE - 1)) ? TBL_IDX_W'(TABLE_SIZE - 1)
                                                           : slot_q[TBL_IDX_W-1:0];

    assign fill_last = (fill_idx_reg == TBL_IDX_W'(TABLE_SIZE - 1));
    assign accept    = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.request)
                begin
                    state_next = ST_ISSUE_ONE;
                end
            end
            ST_ISSUE_ONE: state_next = ST_ISSUE_TWO;
            ST_ISSUE_TWO: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (mm_rsp.valid && (mm_rsp.sel == GEN_TWO))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:      state_next = fill_reg ? ST_FILL_WR : ST_SLOT;
            ST_FILL_WR:   state_next = ST_ISSUE_ONE;
            ST_SLOT:      state_next = ST_READ;
            ST_READ:      state_next = ST_TAKE;
            ST_TAKE:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready  = 1'b0;
        mm_req     = '0;
        ram_we     = 1'b0;
        ram_waddr  = slot_reg;
        ram_re     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_ISSUE_ONE:
            begin
                mm_req.valid = 1'b1;
                mm_req.sel   = GEN_ONE;
                mm_req.x     = gen_one_reg;
            end
            ST_ISSUE_TWO:
            begin
                mm_req.valid = 1'b1;
                mm_req.sel   = GEN_TWO;
                mm_req.x     = gen_two_reg;
            end
            ST_FILL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_idx_reg;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_TAKE:
            begin
                ram_we = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Generator state, fill control, seed and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            need_fill_reg <= 1'b1;
            fill_reg      <= 1'b0;
            fill_idx_reg  <= '0;
            gen_one_reg   <= '0;
            gen_two_reg   <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Seed both generators at the start of a refill
            if (accept && req.request && need_fill_reg)
            begin
                gen_one_reg  <= seed_reg;
                gen_two_reg  <= seed_reg;
                fill_reg     <= 1'b1;
                fill_idx_reg <= '0;
            end

            // Multiplier results update the generators
            if (mm_rsp.valid)
            begin
                if (mm_rsp.sel == GEN_ONE)
                begin
                    gen_one_reg <= mm_rsp.value;
                end
                else
                begin
                    gen_two_reg <= mm_rsp.value;
                end
            end

            // Table fill progress
            if (state_reg == ST_FILL_WR)
            begin
                fill_idx_reg <= fill_idx_reg + TBL_IDX_W'(1);
                if (fill_last)
                begin
                    fill_reg      <= 1'b0;
                    need_fill_reg <= 1'b0;
                    prev_reg      <= '0;
                end
            end

            if (state_reg == ST_TAKE)
            begin
                prev_reg <= ram_rdata;
            end

            // Output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Seed write forces a refill
            if (cfg_we)
            begin
                seed_reg      <= cfg_wdata;
                need_fill_reg <= 1'b1;
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIFF)
        begin
            diff_reg      <= diff_wrap[VALUE_W-1:0];
            slot_prod_reg <= SLOT_PROD_W'(prev_reg) * SLOT_PROD_W'(TABLE_SIZE);
        end
        if (state_reg == ST_SLOT)
        begin
            slot_reg <= slot_val;
        end
        if (state_reg == ST_TAKE)
        begin
            result_reg <= ram_rdata;
        end
        if (out_load)
        begin
            out_value_reg <= result_reg;
        end
    end

endmodule
